// ----- hw/rtl/slab_page_chunk_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Slab page chunk allocator assertion macros
// Concurrent-assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef SLAB_PAGE_CHUNK_ALLOCATOR_DEFINES_SVH
`define SLAB_PAGE_CHUNK_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF

// Hold c in the same cycle whenever a holds.
`define SPCA_ASSERT_IMPLY(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// Hold c in the cycle after a holds.
`define SPCA_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`else

`define SPCA_ASSERT_IMPLY(label, clk, rst_n, a, c, msg)
`define SPCA_ASSERT_NEXT(label, clk, rst_n, a, c, msg)

`endif

`endif

// ----- hw/rtl/spca_pkg.sv -----
// ----------------------------------------------------------------------------
// spca_pkg
// Shared constants, codes and types of the slab page chunk allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package spca_pkg;

    localparam int MAX_CHUNKS   = 8192;
    localparam int HEADER_BYTES = 8;

    localparam int PAGE_W   = 17;
    localparam int CHUNK_W  = 16;
    localparam int OFFS_W   = 16;
    localparam int STRIDE_W = 17;
    localparam int STAT_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W    = $clog2(MAX_CHUNKS + 1);
    localparam int ADDR_W   = $clog2(MAX_CHUNKS);

    localparam int RESET_PAGE   = 4096;
    localparam int RESET_CHUNK  = 64;
    localparam int RESET_STRIDE = RESET_CHUNK + HEADER_BYTES;
    localparam int RESET_QUO    = RESET_PAGE / RESET_STRIDE;
    localparam int RESET_COUNT  = (RESET_QUO > MAX_CHUNKS) ? MAX_CHUNKS : RESET_QUO;

    localparam int DIV_STEPS = PAGE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK = 2'd1;

    typedef struct packed {
        logic                start;
        logic [PAGE_W-1:0]   dividend;
        logic [STRIDE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PAGE_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ----- hw/rtl/slab_page_chunk_allocator.sv -----
// ----------------------------------------------------------------------------
// slab_page_chunk_allocator
// Fixed-size chunk allocator over one page with a LIFO stack of freed chunks.
// ----------------------------------------------------------------------------
// Each item is accepted and then executed: the accept edge updates the stack
// pointer or fresh index and either launches a read of the freed-chunk stack
// RAM or registers fresh_index * stride; the execute state then loads the
// result beat into the output register; the RAM read is registered. One item
// is in flight at a time, so a push always lands in the RAM before any later
// pop reads it and no forwarding path is needed. A finished result waits in
// the output register while the next item is accepted; that item then holds
// in its execute cycle until the output beat is taken. A configuration write
// (index 0 page bytes, index 1 chunk bytes) resets the page and runs a
// 17-step restoring divide for the chunk count; the input and the
// configuration port stall after the write until the new count is in place.
// Configuration beats are taken only when no item is executing. The stack
// RAM is never cleared: entries are read only after being pushed, so there
// is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "slab_page_chunk_allocator_defines.svh"

module slab_page_chunk_allocator (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // item input
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_operation,
    input  wire logic [spca_pkg::OFFS_W-1:0]      i_chunk_offset,
    // result output
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic      [spca_pkg::STAT_W-1:0]      o_status,
    output logic      [spca_pkg::OFFS_W-1:0]      o_granted_offset,
    output logic                                  o_page_full,
    output logic                                  o_page_idle,
    // configuration write
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [spca_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [spca_pkg::PAGE_W-1:0]      i_cfg_data
);

    import spca_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    // where the granted offset of the executing item comes from
    localparam logic [1:0] K_PLAIN = 2'd0;
    localparam logic [1:0] K_POP   = 2'd1;
    localparam logic [1:0] K_FRESH = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [1:0]          r_kind, n_kind;
    logic [STAT_W-1:0]   r_stat, n_stat;
    logic [PAGE_W-1:0]   r_page, n_page;
    logic [CHUNK_W-1:0]  r_chunk, n_chunk;
    logic [STRIDE_W-1:0] r_stride, n_stride;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_fresh, n_fresh;
    logic [CNT_W-1:0]    r_depth, n_depth;
    logic [OFFS_W-1:0]   r_prod;

    logic                r_out_valid, n_out_valid;
    logic [STAT_W-1:0]   r_out_stat;
    logic [OFFS_W-1:0]   r_out_offs;
    logic                r_out_full;
    logic                r_out_idle;

    logic in_accept;
    logic cfg_we;
    logic cfg_hit;
    logic out_free;
    logic load_out;

    logic                     ram_we;
    logic                     ram_re;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [OFFS_W-1:0]        ram_rdata;
    logic [CNT_W-1:0]         depth_dec;
    logic [CNT_W+STRIDE_W-1:0] prod_full;
    logic [OFFS_W-1:0]        res_offs;

    t_div_req div_req;
    t_div_rsp div_rsp;

    // Handshakes: configuration wins over an item in the same cycle.
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign load_out    = (r_state == S_EXEC) && out_free;

    assign depth_dec = r_depth - 1'b1;
    assign prod_full = r_fresh * r_stride;

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_stat   = r_stat;
        n_page   = r_page;
        n_chunk  = r_chunk;
        n_stride = r_stride;
        n_count  = r_count;
        n_fresh  = r_fresh;
        n_depth  = r_depth;
        cfg_hit  = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (cfg_we) begin
                    unique case (i_cfg_index)
                        CFG_PAGE: begin
                            n_page  = i_cfg_data;
                            cfg_hit = 1'b1;
                        end
                        CFG_CHUNK: begin
                            n_chunk = i_cfg_data[CHUNK_W-1:0];
                            cfg_hit = 1'b1;
                        end
                        default: begin
                            // drop writes beyond the register list
                        end
                    endcase
                    if (cfg_hit) begin
                        // Reinitialize the page and start the count divide.
                        n_stride = STRIDE_W'(n_chunk) + STRIDE_W'(HEADER_BYTES);
                        n_fresh  = '0;
                        n_depth  = '0;
                        n_state  = S_DIV;
                    end
                end else if (in_accept) begin
                    n_state = S_EXEC;
                    n_kind  = K_PLAIN;
                    n_stat  = ST_OK;
                    if (i_operation == OP_ALLOC) begin
                        if (r_depth != '0) begin
                            // Pop: the most recently freed chunk comes first.
                            ram_re  = 1'b1;
                            n_depth = depth_dec;
                            n_kind  = K_POP;
                        end else if (r_fresh < r_count) begin
                            // Bump: take the next never-used chunk.
                            n_fresh = r_fresh + 1'b1;
                            n_kind  = K_FRESH;
                        end else begin
                            n_stat = ST_EMPTY;
                        end
                    end else begin
                        // The count never exceeds the stack size, so this
                        // compare also bounds the RAM address.
                        if (r_depth < r_count) begin
                            ram_we  = 1'b1;
                            n_depth = r_depth + 1'b1;
                        end else begin
                            n_stat = ST_FULL;
                        end
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    // Saturate the chunk count at the stack size.
                    if (div_rsp.quotient > PAGE_W'(MAX_CHUNKS)) begin
                        n_count = CNT_W'(MAX_CHUNKS);
                    end else begin
                        n_count = CNT_W'(div_rsp.quotient);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign ram_waddr = r_depth[ADDR_W-1:0];
    assign ram_raddr = depth_dec[ADDR_W-1:0];

    assign div_req.start    = cfg_we && cfg_hit;
    assign div_req.dividend = n_page;
    assign div_req.divisor  = n_stride;

    spca_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    spca_ram #(
        .WIDTH (OFFS_W),
        .DEPTH (MAX_CHUNKS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_chunk_offset),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Result offset: popped entry, or fresh payload offset wrapped to 16 bits.
    always_comb begin
        case (r_kind)
            K_POP:   res_offs = ram_rdata;
            K_FRESH: res_offs = r_prod + OFFS_W'(HEADER_BYTES);
            default: res_offs = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= K_PLAIN;
            r_stat      <= ST_OK;
            r_page      <= PAGE_W'(RESET_PAGE);
            r_chunk     <= CHUNK_W'(RESET_CHUNK);
            r_stride    <= STRIDE_W'(RESET_STRIDE);
            r_count     <= CNT_W'(RESET_COUNT);
            r_fresh     <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_stat      <= n_stat;
            r_page      <= n_page;
            r_chunk     <= n_chunk;
            r_stride    <= n_stride;
            r_count     <= n_count;
            r_fresh     <= n_fresh;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: the product uses the fresh index before the bump.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_prod <= prod_full[OFFS_W-1:0];
        end
        if (load_out) begin
            r_out_stat <= r_stat;
            r_out_offs <= (r_stat == ST_OK) ? res_offs : '0;
            r_out_full <= (r_fresh == r_count) && (r_depth == '0);
            r_out_idle <= (r_depth == r_fresh);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_stat;
    assign o_granted_offset = r_out_offs;
    assign o_page_full      = r_out_full;
    assign o_page_idle      = r_out_idle;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `SPCA_ASSERT_IMPLY(a_depth_bound, i_clk, i_rst_n,
        1'b1, r_depth <= r_count, "stack depth above chunk count")
    `SPCA_ASSERT_IMPLY(a_fresh_bound, i_clk, i_rst_n,
        1'b1, r_fresh <= r_count, "fresh index above chunk count")
    `SPCA_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n,
        in_accept, r_state == S_EXEC, "accepted item did not execute")
    `SPCA_ASSERT_IMPLY(a_fail_zero, i_clk, i_rst_n,
        r_out_valid && (r_out_stat != ST_OK), r_out_offs == '0,
        "failed beat carries an offset")

endmodule

`default_nettype wire

// ----- hw/rtl/spca_ram.sv -----
// ----------------------------------------------------------------------------
// spca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/spca_div.sv -----
// ----------------------------------------------------------------------------
// spca_div
// Restoring divider, one quotient bit per cycle, for the chunk count.
// ----------------------------------------------------------------------------
`default_nettype none

module spca_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire spca_pkg::t_div_req  i_req,
    output spca_pkg::t_div_rsp       o_rsp
);

    import spca_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PAGE_W:0]      r_rem;
    logic [PAGE_W-1:0]    r_quo;
    logic [STRIDE_W-1:0]  r_dvs;

    logic [PAGE_W:0] shifted;
    logic [PAGE_W:0] dvs_ext;
    logic [PAGE_W:0] diff;
    logic            ge;

    assign shifted = {r_rem[PAGE_W-1:0], r_quo[PAGE_W-1]};
    assign dvs_ext = (PAGE_W + 1)'(r_dvs);
    assign ge      = shifted >= dvs_ext;
    assign diff    = shifted - dvs_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // shift the dividend out of the quotient register as quotient bits enter
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff : shifted;
            r_quo <= {r_quo[PAGE_W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire
